FILE: hdl/rcdd_pkg.sv
// Shared constants, types and coefficient tables for the differential-drive mixer.
// Depends on nothing; imported by rc_differential_drive_mixer.
`timescale 1ns / 1ps

package rcdd_pkg;

    // Widths of the radio channels and of the fixed-point coefficients.
    localparam int CHANNEL_WIDTH  = 10;
    localparam int COEF_FRAC_BITS = 16;

    // Configuration register widths.
    localparam int LIMIT_WIDTH  = 15;
    localparam int THRESH_WIDTH = 10;
    localparam int SPEED_WIDTH  = 16;

    // Configuration port.
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = LIMIT_WIDTH;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WHEEL_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEVEL_HIGH  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEVEL_LOW   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [LIMIT_WIDTH-1:0]  RST_WHEEL_LIMIT = 15'd200;
    localparam logic [THRESH_WIDTH-1:0] RST_LEVEL_HIGH  = 10'sd50;
    localparam logic [THRESH_WIDTH-1:0] RST_LEVEL_LOW   = -10'sd50;

    // Result action codes.
    typedef logic [1:0] t_action;
    localparam t_action ACT_NONE  = 2'd0;
    localparam t_action ACT_DRIVE = 2'd1;
    localparam t_action ACT_STOP  = 2'd2;

    // Speed level codes, also the index into the coefficient tables.
    typedef logic [1:0] t_level;
    localparam t_level LVL_LOW  = 2'd0;
    localparam t_level LVL_MID  = 2'd1;
    localparam t_level LVL_HIGH = 2'd2;
    localparam int     NUM_LEVELS = 3;

    // Coefficients are kept in Q24 and reduced to Q(COEF_FRAC_BITS).
    localparam int BASE_FRAC  = 24;
    localparam int Q24_WIDTH  = 25;
    localparam int COEF_SHIFT = BASE_FRAC - COEF_FRAC_BITS;
    localparam int COEF_WIDTH = COEF_FRAC_BITS + 1;

    // Reduce a Q24 coefficient, rounding half up.
    function automatic logic [COEF_WIDTH-1:0] coef_round(input logic [Q24_WIDTH-1:0] q);
        logic [Q24_WIDTH:0] t;
        t = (({1'b0, q} << 1) >> COEF_SHIFT) + 1'b1;
        return COEF_WIDTH'(t >> 1);
    endfunction

    // Linear coefficient Lv*9.549724/20 and angular Av*0.26*9.549724/20 per level.
    localparam logic [COEF_WIDTH-1:0] LIN_COEF [NUM_LEVELS] = '{
        coef_round(25'd4005445), coef_round(25'd8010889), coef_round(25'd20027223)
    };
    localparam logic [COEF_WIDTH-1:0] ANG_COEF [NUM_LEVELS] = '{
        coef_round(25'd2082831), coef_round(25'd4165662), coef_round(25'd6248494)
    };

endpackage

FILE: hdl/rc_differential_drive_mixer.sv
// Radio-control differential-drive mixer: level select, unicycle mixing, round and clamp.
// Depends on rcdd_pkg for widths, codes and the coefficient tables.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                  Payload
//  in        input      i_in_valid / o_in_ready    req_type, link_ok, four channels
//  out       output     o_out_valid / i_out_ready  action, right_speed, left_speed
//  cfg       input      i_cfg_valid / o_cfg_ready  cfg_index, cfg_data
//
//  Each item passes an input register and then a result register, with the
//  single multiply-add-round-clamp pass between the two; one item per cycle
//  sustained while the output is not stalled.
//  Reset is synchronous, active low; the stop flag resets to set.
//  A stalled output holds its result; the input register keeps taking items
//  until both stages are full.
module rc_differential_drive_mixer (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input item channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_req_type,
    input  logic                                   i_link_ok,
    input  logic signed [rcdd_pkg::CHANNEL_WIDTH-1:0] i_yaw_channel,
    input  logic signed [rcdd_pkg::CHANNEL_WIDTH-1:0] i_throttle_channel,
    input  logic signed [rcdd_pkg::CHANNEL_WIDTH-1:0] i_arm_channel,
    input  logic signed [rcdd_pkg::CHANNEL_WIDTH-1:0] i_level_channel,
    // Result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output rcdd_pkg::t_action                      o_action,
    output logic signed [rcdd_pkg::SPEED_WIDTH-1:0]  o_right_speed,
    output logic signed [rcdd_pkg::SPEED_WIDTH-1:0]  o_left_speed,
    // Configuration channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [rcdd_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [rcdd_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_data
);

    import rcdd_pkg::*;

    localparam int CMP_WIDTH   = (CHANNEL_WIDTH > THRESH_WIDTH) ? CHANNEL_WIDTH + 1
                                                                : THRESH_WIDTH + 1;
    localparam int PROD_WIDTH  = COEF_WIDTH + 1 + CHANNEL_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 1;
    localparam int Q_WIDTH     = SUM_WIDTH + 1 - COEF_FRAC_BITS;
    localparam int CLAMP_WIDTH = (Q_WIDTH > LIMIT_WIDTH) ? Q_WIDTH : LIMIT_WIDTH;

    // Configuration registers
    logic [LIMIT_WIDTH-1:0]         r_wheel_limit;
    logic signed [THRESH_WIDTH-1:0] r_level_high;
    logic signed [THRESH_WIDTH-1:0] r_level_low;

    // Input stage
    logic                            r_s1_vld;
    logic                            r_req_type;
    logic                            r_link_ok;
    logic signed [CHANNEL_WIDTH-1:0] r_yaw;
    logic signed [CHANNEL_WIDTH-1:0] r_throttle;
    logic signed [CHANNEL_WIDTH-1:0] r_arm;
    logic signed [CHANNEL_WIDTH-1:0] r_level;

    // Result stage and state
    logic                          r_out_vld;
    t_action                       r_action;
    logic signed [SPEED_WIDTH-1:0] r_right;
    logic signed [SPEED_WIDTH-1:0] r_left;
    logic                          r_stop_issued;

    // Datapath and control signals
    logic                          w_out_load;
    logic                          w_s1_advance;
    logic                          w_in_xfer;
    logic signed [CMP_WIDTH-1:0]   w_lvl_ext;
    logic signed [CMP_WIDTH-1:0]   w_hi_ext;
    logic signed [CMP_WIDTH-1:0]   w_lo_ext;
    t_level                        w_sel;
    logic signed [COEF_WIDTH:0]    w_kl;
    logic signed [COEF_WIDTH:0]    w_ka;
    logic signed [PROD_WIDTH-1:0]  w_prod_lin;
    logic signed [PROD_WIDTH-1:0]  w_prod_ang;
    logic signed [SUM_WIDTH-1:0]   w_sum_left;
    logic signed [SUM_WIDTH-1:0]   w_sum_right;
    logic [LIMIT_WIDTH-1:0]        w_mag_left;
    logic [LIMIT_WIDTH-1:0]        w_mag_right;
    t_action                       n_action;
    logic signed [SPEED_WIDTH-1:0] n_right;
    logic signed [SPEED_WIDTH-1:0] n_left;
    logic                          n_stop_issued;

    // Round a sum to an integer half away from zero and clamp its magnitude.
    function automatic logic [LIMIT_WIDTH-1:0] round_mag(
        input logic signed [SUM_WIDTH-1:0] sum,
        input logic [LIMIT_WIDTH-1:0]      lim
    );
        logic [SUM_WIDTH-1:0]   mag;
        logic [SUM_WIDTH:0]     biased;
        logic [CLAMP_WIDTH-1:0] q;
        logic [CLAMP_WIDTH-1:0] lim_ext;
        mag     = sum[SUM_WIDTH-1] ? SUM_WIDTH'(-sum) : SUM_WIDTH'(sum);
        biased  = {1'b0, mag} + ((SUM_WIDTH+1)'(1) << (COEF_FRAC_BITS - 1));
        q       = CLAMP_WIDTH'(biased >> COEF_FRAC_BITS);
        lim_ext = CLAMP_WIDTH'(lim);
        return (q > lim_ext) ? lim : LIMIT_WIDTH'(q);
    endfunction

    // Pipeline handshake: the result register loads when empty or drained.
    assign w_out_load   = !r_out_vld || i_out_ready;
    assign w_s1_advance = r_s1_vld && w_out_load;
    assign o_in_ready   = !r_s1_vld || w_out_load;
    assign w_in_xfer    = i_in_valid && o_in_ready;
    assign o_cfg_ready  = 1'b1;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_limit <= RST_WHEEL_LIMIT;
            r_level_high  <= RST_LEVEL_HIGH;
            r_level_low   <= RST_LEVEL_LOW;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WHEEL_LIMIT: r_wheel_limit <= i_cfg_data[LIMIT_WIDTH-1:0];
                REG_LEVEL_HIGH:  r_level_high  <= i_cfg_data[THRESH_WIDTH-1:0];
                REG_LEVEL_LOW:   r_level_low   <= i_cfg_data[THRESH_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_req_type <= i_req_type;
            r_link_ok  <= i_link_ok;
            r_yaw      <= i_yaw_channel;
            r_throttle <= i_throttle_channel;
            r_arm      <= i_arm_channel;
            r_level    <= i_level_channel;
        end
    end

    // Speed level: the high test wins over the low test.
    always_comb begin
        w_lvl_ext = CMP_WIDTH'(r_level);
        w_hi_ext  = CMP_WIDTH'(r_level_high);
        w_lo_ext  = CMP_WIDTH'(r_level_low);
        if (w_lvl_ext > w_hi_ext) begin
            w_sel = LVL_HIGH;
        end else if (w_lvl_ext < w_lo_ext) begin
            w_sel = LVL_LOW;
        end else begin
            w_sel = LVL_MID;
        end
    end

    // Unicycle mixing: left = Klin*thr - Kang*yaw, right = Klin*thr + Kang*yaw.
    assign w_kl        = $signed({1'b0, LIN_COEF[w_sel]});
    assign w_ka        = $signed({1'b0, ANG_COEF[w_sel]});
    assign w_prod_lin  = w_kl * r_throttle;
    assign w_prod_ang  = w_ka * r_yaw;
    assign w_sum_left  = SUM_WIDTH'(w_prod_lin) - SUM_WIDTH'(w_prod_ang);
    assign w_sum_right = SUM_WIDTH'(w_prod_lin) + SUM_WIDTH'(w_prod_ang);
    assign w_mag_left  = round_mag(w_sum_left, r_wheel_limit);
    assign w_mag_right = round_mag(w_sum_right, r_wheel_limit);

    // Command decision and wheel outputs; the right wheel is negated.
    always_comb begin
        n_action      = ACT_NONE;
        n_right       = '0;
        n_left        = '0;
        n_stop_issued = r_stop_issued;
        if (!r_link_ok) begin
            if (!r_stop_issued) begin
                n_action      = ACT_STOP;
                n_stop_issued = 1'b1;
            end
        end else if (!r_req_type && !r_arm[CHANNEL_WIDTH-1]) begin
            n_action      = ACT_DRIVE;
            n_stop_issued = 1'b0;
            n_left  = w_sum_left[SUM_WIDTH-1]  ? -SPEED_WIDTH'(w_mag_left)
                                               :  SPEED_WIDTH'(w_mag_left);
            n_right = w_sum_right[SUM_WIDTH-1] ?  SPEED_WIDTH'(w_mag_right)
                                               : -SPEED_WIDTH'(w_mag_right);
        end
    end

    // Result register and stop flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld     <= 1'b0;
            r_stop_issued <= 1'b1;
        end else begin
            if (w_out_load) begin
                r_out_vld <= r_s1_vld;
            end
            if (w_s1_advance) begin
                r_stop_issued <= n_stop_issued;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_advance) begin
            r_action <= n_action;
            r_right  <= n_right;
            r_left   <= n_left;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_action      = r_action;
    assign o_right_speed = r_right;
    assign o_left_speed  = r_left;

endmodule
